// ===== rtl/core/utc_date_to_epoch_seconds_macros.svh =====
// Assertion macros used by the checker file ute_checker.
`ifndef UTC_DATE_TO_EPOCH_SECONDS_MACROS_SVH
`define UTC_DATE_TO_EPOCH_SECONDS_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define UTE_ASSERT_IMPLY(label, clk, dis, a, c) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
    else $error("utc_date_to_epoch_seconds: same-cycle check failed");

// Next-cycle implication, disabled while dis is high.
`define UTE_ASSERT_NEXT(label, clk, dis, a, c) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
    else $error("utc_date_to_epoch_seconds: next-cycle check failed");

`endif

// ===== rtl/core/ute_pkg.sv =====
`timescale 1ns / 1ps

package ute_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;
  localparam int unsigned EpochW   = 38;

  localparam int unsigned DaysW    = 23;
  localparam int unsigned TodW     = 17;
  localparam int unsigned CumW     = 9;
  localparam int unsigned ProdW    = DaysW + TodW;

  localparam int unsigned PipeDepth = 5;

  localparam logic [YearW-1:0]  EpochYear   = YearW'(1970);
  localparam logic [DaysW-1:0]  DaysPerYear = DaysW'(365);
  localparam logic [DaysW-1:0]  Leaps1969   = DaysW'(477);
  localparam logic [ProdW-1:0]  SecsPerDay  = ProdW'(86400);
  localparam logic [TodW-1:0]   SecsPerHour = TodW'(3600);
  localparam logic [TodW-1:0]   SecsPerMin  = TodW'(60);
  localparam logic [ProdW:0]    OutMax      = (ProdW + 1)'((64'd1 << EpochW) - 64'd1);

  localparam int unsigned RecipShift = 17;
  localparam logic [12:0] Recip25    = 13'd5243;

  typedef struct packed {
    logic                err;
    logic [YearW-1:0]    ym;
    logic [11:0]         q4;
    logic [7:0]          d100;
    logic [5:0]          d400;
    logic [11:0]         y4;
    logic [7:0]          yq;
    logic [3:0]          ylow;
    logic                m_gt2;
    logic [CumW-1:0]     cum;
    logic [DayW-1:0]     day;
    logic [TodW-1:0]     tod;
  } front_t;

  function automatic logic [7:0] div25(input logic [11:0] q);
    logic [24:0] p;
    p = 25'(q) * 25'(Recip25);
    return p[RecipShift +: 8];
  endfunction

  function automatic logic [CumW-1:0] cum_days(input logic [MonthW-1:0] m);
    logic [CumW-1:0] c;
    case (m)
      4'd1:    c = CumW'(0);
      4'd2:    c = CumW'(31);
      4'd3:    c = CumW'(59);
      4'd4:    c = CumW'(90);
      4'd5:    c = CumW'(120);
      4'd6:    c = CumW'(151);
      4'd7:    c = CumW'(181);
      4'd8:    c = CumW'(212);
      4'd9:    c = CumW'(243);
      4'd10:   c = CumW'(273);
      4'd11:   c = CumW'(304);
      4'd12:   c = CumW'(334);
      default: c = CumW'(0);
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ute_if.sv =====
`timescale 1ns / 1ps

interface ute_date_if;
  logic                          valid;
  logic                          ready;
  logic [ute_pkg::YearW-1:0]     year;
  logic [ute_pkg::MonthW-1:0]    month;
  logic [ute_pkg::DayW-1:0]      day;
  logic [ute_pkg::HourW-1:0]     hour;
  logic [ute_pkg::MinuteW-1:0]   minute;
  logic [ute_pkg::SecondW-1:0]   second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface ute_secs_if;
  logic                          valid;
  logic                          ready;
  logic [ute_pkg::EpochW-1:0]    epoch_seconds;
  logic                          before_epoch;

  modport source (output valid, epoch_seconds, before_epoch, input ready);
  modport sink   (input valid, epoch_seconds, before_epoch, output ready);
endinterface

// ===== rtl/core/utc_date_to_epoch_seconds.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                               Handshake
// date     in   year, month, day, hour, minute, sec   valid / ready
// result   out  epoch_seconds, before_epoch           valid / ready
//
// Five register stages; an accepted transaction passes through all five before its result is valid.
// One transaction per cycle is accepted while the output is taken.
// Each stage holds its own valid bit, so a stall at the output fills bubbles first.
// Reset clears all valid bits; data registers are not reset.

module utc_date_to_epoch_seconds (
  input  logic       clk,
  input  logic       rst,
  ute_date_if.sink   date,
  ute_secs_if.source result
);

  ute_pkg::front_t front;
  ute_pkg::front_t s1;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic                          err2;
  logic [ute_pkg::DaysW-1:0]     ydays2;
  logic                          leap2;
  logic                          m_gt2_2;
  logic [ute_pkg::CumW-1:0]      cum2;
  logic [ute_pkg::DayW-1:0]      day2;
  logic [ute_pkg::TodW-1:0]      tod2;

  logic                          err3;
  logic [ute_pkg::DaysW-1:0]     dm3;
  logic [ute_pkg::TodW-1:0]      tod3;

  logic                          err4;
  logic [ute_pkg::ProdW-1:0]     prod4;
  logic [ute_pkg::TodW-1:0]      tod4;

  logic [ute_pkg::EpochW-1:0]    epoch5;
  logic                          before5;

  logic [ute_pkg::DaysW-1:0]     ydays_next;
  logic [11:0]                   r25;
  logic                          leap_next;
  logic [ute_pkg::DaysW-1:0]     days_sum;
  logic [ute_pkg::ProdW:0]       secs_sum;

  ute_front u_front (
    .year   (date.year),
    .month  (date.month),
    .day    (date.day),
    .hour   (date.hour),
    .minute (date.minute),
    .second (date.second),
    .front  (front)
  );

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign date.ready = en1;

  always_comb begin
    ydays_next = ute_pkg::DaysW'(s1.ym) * ute_pkg::DaysPerYear
               + ute_pkg::DaysW'(s1.q4) - ute_pkg::DaysW'(s1.d100)
               + ute_pkg::DaysW'(s1.d400) - ute_pkg::Leaps1969;
    r25 = s1.y4 - 12'(s1.yq) * 12'd25;
    leap_next = (s1.ylow[1:0] == 2'b00) && ((r25 != 12'd0) || (s1.ylow == 4'd0));
    days_sum = ydays2 + ute_pkg::DaysW'(cum2)
             + ute_pkg::DaysW'(leap2 && m_gt2_2) + ute_pkg::DaysW'(day2);
    secs_sum = (ute_pkg::ProdW + 1)'(prod4) + (ute_pkg::ProdW + 1)'(tod4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= date.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= front;
    end
    if (en2) begin
      err2    <= s1.err;
      ydays2  <= ydays_next;
      leap2   <= leap_next;
      m_gt2_2 <= s1.m_gt2;
      cum2    <= s1.cum;
      day2    <= s1.day;
      tod2    <= s1.tod;
    end
    if (en3) begin
      err3 <= err2 || (days_sum == ute_pkg::DaysW'(0));
      dm3  <= days_sum - ute_pkg::DaysW'(1);
      tod3 <= tod2;
    end
    if (en4) begin
      err4  <= err3;
      prod4 <= ute_pkg::ProdW'(dm3) * ute_pkg::SecsPerDay;
      tod4  <= tod3;
    end
    if (en5) begin
      before5 <= err4;
      if (err4) begin
        epoch5 <= '0;
      end else if (secs_sum > ute_pkg::OutMax) begin
        epoch5 <= ute_pkg::OutMax[ute_pkg::EpochW-1:0];
      end else begin
        epoch5 <= secs_sum[ute_pkg::EpochW-1:0];
      end
    end
  end

  assign result.valid         = v5;
  assign result.epoch_seconds = epoch5;
  assign result.before_epoch  = before5;

endmodule

// ===== rtl/core/ute_front.sv =====
`timescale 1ns / 1ps

module ute_front (
  input  logic [ute_pkg::YearW-1:0]   year,
  input  logic [ute_pkg::MonthW-1:0]  month,
  input  logic [ute_pkg::DayW-1:0]    day,
  input  logic [ute_pkg::HourW-1:0]   hour,
  input  logic [ute_pkg::MinuteW-1:0] minute,
  input  logic [ute_pkg::SecondW-1:0] second,
  output ute_pkg::front_t             front
);

  logic [ute_pkg::YearW-1:0]  ym1;
  logic [ute_pkg::MonthW-1:0] mc;
  logic [7:0]                 d400w;

  always_comb begin
    ym1 = year - ute_pkg::YearW'(1);
    if (month < ute_pkg::MonthW'(1)) begin
      mc = ute_pkg::MonthW'(1);
    end else if (month > ute_pkg::MonthW'(12)) begin
      mc = ute_pkg::MonthW'(12);
    end else begin
      mc = month;
    end
    d400w = ute_pkg::div25({2'b00, ym1[13:4]});

    front.err   = year < ute_pkg::EpochYear;
    front.ym    = year - ute_pkg::EpochYear;
    front.q4    = ym1[13:2];
    front.d100  = ute_pkg::div25(ym1[13:2]);
    front.d400  = d400w[5:0];
    front.y4    = year[13:2];
    front.yq    = ute_pkg::div25(year[13:2]);
    front.ylow  = year[3:0];
    front.m_gt2 = mc > ute_pkg::MonthW'(2);
    front.cum   = ute_pkg::cum_days(mc);
    front.day   = day;
    front.tod   = ute_pkg::TodW'(hour) * ute_pkg::SecsPerHour
                + ute_pkg::TodW'(minute) * ute_pkg::SecsPerMin
                + ute_pkg::TodW'(second);
  end

endmodule

// ===== rtl/core/ute_checker.sv =====
`timescale 1ns / 1ps
`include "utc_date_to_epoch_seconds_macros.svh"

module ute_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ute_pkg::EpochW-1:0] epoch_seconds,
  input logic                       before_epoch
);

  localparam int unsigned CntW = $clog2(ute_pkg::PipeDepth + 1);

  logic [CntW-1:0] inflight;
  logic [CntW-1:0] inflight_next;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign inflight_next = inflight + CntW'(in_acc) - CntW'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `UTE_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(epoch_seconds) && $stable(before_epoch))
  `UTE_ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && before_epoch, epoch_seconds == '0)
  `UTE_ASSERT_IMPLY(a_occupancy, clk, rst, 1'b1, inflight <= CntW'(ute_pkg::PipeDepth))
  `UTE_ASSERT_IMPLY(a_no_phantom, clk, rst, out_valid, inflight != '0)

endmodule

bind utc_date_to_epoch_seconds ute_checker u_ute_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (date.valid),
  .in_ready      (date.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .epoch_seconds (result.epoch_seconds),
  .before_epoch  (result.before_epoch)
);
